@@ rtl/tffp_pkg.sv @@
`default_nettype none

package tffp_pkg;

    // Widths of the port fields.
    localparam int IDX_W = 6;
    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int PIX_W = 8;

    localparam logic [PIX_W-1:0] THRESH_RESET = 8'd128;

    // Values of the op field.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_STEP  = 1'b1;

endpackage

`default_nettype wire

@@ rtl/threshold_frame_falling_particles.sv @@
`default_nettype none

// Thresholded frame store with falling particles.
//
// Command channel: an item is taken at a clock edge where i_start is high and
// o_busy is low. i_op selects a pixel write or a step of all particles.
// A pixel write produces nothing; pixel writes may follow each other in every
// cycle while o_busy is low. A step emits PARTICLES words on the result ports,
// one per o_valid strobe, in particle order, with o_last on the final one.
// Each particle passes through S_PREAD, S_FIRST and S_TEST, then S_SCAN once
// per row scanned upward when the pixel under it is dark; the scan reads one
// frame row per cycle from the frame memory's single read port. o_busy stays
// high until the last word is on the ports.
// Results cannot be held off: each word is valid for exactly one cycle.
// Reset starts a clearing pass over all HEIGHT rows of the frame memory, one
// row per cycle, during which o_busy is high. The threshold register
// may be written through the config channel at any time the block is idle;
// o_cfg_ready is always high.

module threshold_frame_falling_particles
    import tffp_pkg::*;
#(
    parameter int WIDTH     = 640,
    parameter int HEIGHT    = 480,
    parameter int PARTICLES = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic             i_op,
    input  wire logic [COL_W-1:0] i_pixel_column,
    input  wire logic [ROW_W-1:0] i_pixel_row,
    input  wire logic [PIX_W-1:0] i_red,
    input  wire logic [PIX_W-1:0] i_green,
    input  wire logic [PIX_W-1:0] i_blue,

    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [PIX_W-1:0] i_cfg_data,

    output logic                  o_valid,
    output logic [IDX_W-1:0]      o_particle_index,
    output logic [COL_W-1:0]      o_particle_column,
    output logic [ROW_W-1:0]      o_particle_row,
    output logic                  o_last
);

    localparam int RW    = $clog2(HEIGHT);
    localparam int CW    = $clog2(WIDTH);
    localparam int IW    = $clog2(PARTICLES);
    localparam int AW    = $clog2(2 * PARTICLES);
    localparam int CSTEP = (WIDTH - 1) / (PARTICLES - 1);
    localparam int CREM  = (WIDTH - 1) % (PARTICLES - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_PREAD = 6'b000100,
        S_FIRST = 6'b001000,
        S_TEST  = 6'b010000,
        S_SCAN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [RW-1:0] r_clr, n_clr;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_acc, n_acc;
    logic [RW-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_thresh;

    // Frame store: one word per frame row, one bit per pixel.
    logic [WIDTH-1:0] r_frame [HEIGHT];
    logic [WIDTH-1:0] r_fr_data;
    logic [RW-1:0]    r_fr_tag;
    logic [RW-1:0]    fr_rd_addr;

    // Particle row store with a valid bit per entry.
    logic [RW-1:0]        r_prow [PARTICLES];
    logic [PARTICLES-1:0] r_pvalid;
    logic [RW-1:0]        r_pr_data;
    logic                 r_pr_vld;

    logic             fin;
    logic [RW-1:0]    new_row;
    logic [RW-1:0]    cur_row;
    logic [AW-1:0]    acc_sum;
    logic             is_last;
    logic             pix_we;
    logic             pix_lit;
    logic [PIX_W-1:0] max_rg;
    logic [PIX_W-1:0] max_rgb;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_last;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign max_rg  = (i_green > i_red) ? i_green : i_red;
    assign max_rgb = (i_blue > max_rg) ? i_blue : max_rg;
    assign pix_lit = (max_rgb > r_thresh);
    assign pix_we  = i_start && !o_busy && (i_op == OP_PIXEL)
                     && (32'(i_pixel_column) < WIDTH) && (32'(i_pixel_row) < HEIGHT);

    assign is_last = (r_idx == IW'(PARTICLES - 1));
    assign cur_row = r_pr_vld ? r_pr_data : '0;
    assign acc_sum = r_acc + AW'(CREM);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_idx      = r_idx;
        n_col      = r_col;
        n_acc      = r_acc;
        n_row      = r_row;
        fr_rd_addr = r_fr_tag - RW'(1);
        fin        = 1'b0;
        new_row    = '0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + RW'(1);
                if (r_clr == RW'(HEIGHT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start && (i_op == OP_STEP)) begin
                    n_state = S_PREAD;
                    n_idx   = '0;
                    n_col   = '0;
                    n_acc   = '0;
                end
            end
            S_PREAD: begin
                n_state = S_FIRST;
            end
            S_FIRST: begin
                fr_rd_addr = cur_row;
                n_row      = cur_row;
                n_state    = S_TEST;
            end
            S_TEST: begin
                if (r_fr_data[r_col]) begin
                    fin     = 1'b1;
                    new_row = (r_row == RW'(HEIGHT - 1)) ? '0 : r_row + RW'(1);
                end else if (r_row == '0) begin
                    fin = 1'b1;
                end else begin
                    fr_rd_addr = r_row - RW'(1);
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // One row per cycle: the row read now is the one above the
                // row whose data has just come back.
                if (r_fr_data[r_col]) begin
                    fin     = 1'b1;
                    new_row = r_fr_tag;
                end else if (r_fr_tag == '0) begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase

        if (fin) begin
            if (is_last) begin
                n_state = S_IDLE;
            end else begin
                n_state = S_PREAD;
                n_idx   = r_idx + IW'(1);
                if (acc_sum >= AW'(PARTICLES - 1)) begin
                    n_acc = acc_sum - AW'(PARTICLES - 1);
                    n_col = r_col + CW'(CSTEP + 1);
                end else begin
                    n_acc = acc_sum;
                    n_col = r_col + CW'(CSTEP);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_col       <= '0;
            r_acc       <= '0;
            r_thresh    <= THRESH_RESET;
            r_pvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_idx       <= n_idx;
            r_col       <= n_col;
            r_acc       <= n_acc;
            r_out_valid <= fin;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
            if (fin) begin
                r_pvalid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        if (fin) begin
            r_out_idx  <= IDX_W'(r_idx);
            r_out_col  <= COL_W'(r_col);
            r_out_row  <= ROW_W'(new_row);
            r_out_last <= is_last;
        end
    end

    // Frame memory: a whole row is cleared during the pass, else one bit
    // is written per pixel.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_frame[r_clr] <= '0;
        end else if (pix_we) begin
            r_frame[RW'(i_pixel_row)][CW'(i_pixel_column)] <= pix_lit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fr_data <= r_frame[fr_rd_addr];
        r_fr_tag  <= fr_rd_addr;
    end

    // Particle row memory. The write for one particle and the read for the
    // next one never address the same entry.
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_prow[r_idx] <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pr_data <= r_prow[r_idx];
        r_pr_vld  <= r_pvalid[r_idx];
    end

    assign o_valid           = r_out_valid;
    assign o_particle_index  = r_out_idx;
    assign o_particle_column = r_out_col;
    assign o_particle_row    = r_out_row;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire

@@ rtl/tffp_checker.sv @@
`default_nettype none

module tffp_checker
    import tffp_pkg::*;
#(
    parameter int PARTICLES = 64
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_start,
    input wire logic             i_op,
    input wire logic             o_busy,
    input wire logic             o_valid,
    input wire logic [IDX_W-1:0] o_particle_index,
    input wire logic [COL_W-1:0] o_particle_column,
    input wire logic             o_last
);

    // Every particle needs a read of its row before its word, so two words
    // never come in consecutive cycles.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes in consecutive cycles");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_particle_index == IDX_W'(PARTICLES - 1))))
        else $error("last flag does not match the final particle");

    a_busy_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("block idle in the middle of a step");

    a_first_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_particle_index == '0)) |-> (o_particle_column == '0))
        else $error("first particle not in column zero");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_STEP)) |=> o_busy)
        else $error("accepted step did not make the block busy");

endmodule

bind threshold_frame_falling_particles tffp_checker #(
    .PARTICLES(PARTICLES)
) u_tffp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .i_op             (i_op),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_particle_index (o_particle_index),
    .o_particle_column(o_particle_column),
    .o_last           (o_last)
);

`default_nettype wire
